FILE: src/wth_pkg.sv
`default_nettype none

package wth_pkg;

    // FNV-1a 64-bit constants.
    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

    // Word length saturates at the top of its field.
    localparam int unsigned LEN_W = 16;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // Character codes used by the tokenizer.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_APOS    = 8'h27;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Payload of one input transaction.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } wth_text_t;

    // Payload of one result transaction.
    typedef struct packed {
        logic [63:0]      word_hash;
        logic [LEN_W-1:0] word_length;
    } wth_word_t;

    // Fold A-Z to a-z; every other byte passes unchanged.
    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
        begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

    // Multiply by the FNV prime modulo 2^64. The prime is 2^40 + 2^8 + 0xb3,
    // so the product is a sum of seven shifted copies of the operand.
    function automatic logic [63:0] mul_prime(input logic [63:0] x);
        logic [63:0] p;
        p = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: src/wth_stream_if.sv
`default_nettype none

// Valid/ready channel carrying one payload per transaction.
interface wth_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/wth_tokenizer.sv
`default_nettype none

module wth_tokenizer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire wth_pkg::wth_text_t item,
    output logic                   emit,
    output wth_pkg::wth_word_t     result
);
    import wth_pkg::*;

    logic             inside_word_reg;
    logic             inside_word_next;
    logic [63:0]      running_hash_reg;
    logic [63:0]      running_hash_next;
    logic [LEN_W-1:0] length_count_reg;
    logic [LEN_W-1:0] length_count_next;

    logic [7:0]       lowered;
    logic             letter;
    logic             word_byte;
    logic [63:0]      hash_fold;
    logic [LEN_W-1:0] length_inc;

    // Classify the byte against the current word state.
    assign lowered   = to_lower(item.text_byte);
    assign letter    = (lowered >= CHAR_LOWER_A) && (lowered <= CHAR_LOWER_Z);
    assign word_byte = letter || (inside_word_reg && (lowered == CHAR_APOS));

    // Hash and length with this byte folded in.
    assign hash_fold  = mul_prime(running_hash_reg ^ {56'd0, lowered});
    assign length_inc = (length_count_reg == LEN_MAX) ? LEN_MAX
                                                      : length_count_reg + 1'b1;

    // Decide the result and the next word state.
    always_comb
    begin
        emit               = 1'b0;
        result.word_hash   = running_hash_reg;
        result.word_length = length_count_reg;
        inside_word_next   = inside_word_reg;
        running_hash_next  = running_hash_reg;
        length_count_next  = length_count_reg;
        if (word_byte)
        begin
            result.word_hash   = hash_fold;
            result.word_length = length_inc;
            emit               = step && item.end_of_text;
            if (item.end_of_text)
            begin
                inside_word_next  = 1'b0;
                running_hash_next = FNV_BASIS;
                length_count_next = '0;
            end
            else
            begin
                inside_word_next  = 1'b1;
                running_hash_next = hash_fold;
                length_count_next = length_inc;
            end
        end
        else if (inside_word_reg)
        begin
            // A delimiter or the final byte closes the open word.
            emit              = step;
            inside_word_next  = 1'b0;
            running_hash_next = FNV_BASIS;
            length_count_next = '0;
        end
    end

    // Word state, updated once per processed transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_word_reg  <= 1'b0;
            running_hash_reg <= FNV_BASIS;
            length_count_reg <= '0;
        end
        else if (step)
        begin
            inside_word_reg  <= inside_word_next;
            running_hash_reg <= running_hash_next;
            length_count_reg <= length_count_next;
        end
    end

`ifndef SYNTHESIS
    // With no word open the hash and the count sit at their start values.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !inside_word_reg |-> (running_hash_reg == FNV_BASIS) && (length_count_reg == '0))
        else $error("word state not cleared while no word is open");

    // An emitted word always holds at least one byte.
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> result.word_length != '0)
        else $error("emitted word has zero length");

    // The final byte of a stream always leaves the word closed.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.end_of_text |=> !inside_word_reg)
        else $error("word still open after end of text");

    // An open word closing on a non-word byte must produce a result.
    a_close_emits: assert property (@(posedge clk) disable iff (!rst_n)
        step && inside_word_reg && !word_byte |-> emit)
        else $error("open word closed without a result");
`endif

endmodule

`default_nettype wire

FILE: src/word_tokenizer_fnv1a_hash.sv
`default_nettype none

// Channel   Modport  Payload                          Role
// text      sink     text_byte[8], end_of_text[1]     raw text bytes
// words     source   word_hash[64], word_length[16]   one transaction per finished word
//
// One byte per cycle is accepted while no held result stalls it; a word's result
// follows the byte that closes it (input register, then result register).
// The hash fold is a shift-and-add multiply by the FNV prime between the two.
// Reset clears the word state to an empty word with the FNV offset basis.
// A held result stalls input only when the next byte has to be processed.
module word_tokenizer_fnv1a_hash (
    input wire logic    clk,
    input wire logic    rst_n,
    wth_stream_if.sink   text,
    wth_stream_if.source words
);
    import wth_pkg::*;

    logic      in_valid_reg;
    wth_text_t in_data_reg;
    logic      out_valid_reg;
    wth_word_t out_data_reg;

    logic      advance;
    logic      emit;
    wth_word_t result;

    // The held byte is processed when the result register can take its result.
    assign advance    = in_valid_reg && (!out_valid_reg || words.ready);
    assign text.ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text.valid && text.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            in_data_reg <= text.data;
        end
    end

    // Tokenizer and hash state.
    wth_tokenizer u_tokenizer (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_data_reg),
        .emit   (emit),
        .result (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (words.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= result;
        end
    end

    assign words.valid = out_valid_reg;
    assign words.data  = out_data_reg;

endmodule

`default_nettype wire

FILE: bench/word_tokenizer_fnv1a_hash_test.sv
`timescale 1ns / 1ps

module word_tokenizer_fnv1a_hash_test;

    import wth_pkg::*;

    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned RANDOM_BYTES = 400;

    logic clk;
    logic rst_n;

    wth_stream_if #(.payload_t(wth_text_t)) text_ch ();
    wth_stream_if #(.payload_t(wth_word_t)) words_ch ();

    word_tokenizer_fnv1a_hash u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_ch.sink),
        .words (words_ch.source)
    );

    // Predicted state of the open word.
    logic             acc_open;
    logic [63:0]      acc_hash;
    logic [LEN_W-1:0] acc_len;

    // Finished words still to come out of the block, oldest first.
    wth_word_t words_due[$];

    int unsigned mismatch_count;
    int unsigned idle_cycles;

    // Idling controls shared between the test tasks and the receiver.
    bit          tx_gaps_on;
    bit          rx_gaps_on;
    int unsigned rx_hold_cycles;
    int unsigned rx_stall_left;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length in cycles: mostly none, sometimes short, rarely long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    // True for bytes that can continue an open word, in either case.
    function automatic bit is_word_char(input logic [7:0] b);
        return (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
               (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) || (b == CHAR_APOS);
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = ($urandom_range(0, 1) != 0) ? CHAR_UPPER_A : CHAR_LOWER_A;
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_delim();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom_range(0, 255));
        end
        while (is_word_char(b));
        return b;
    endfunction

    // Close the open word: queue its result if emit is set and start over from the basis.
    function automatic void close_word(input bit emit);
        wth_word_t w;
        if (emit)
        begin
            w.word_hash   = acc_hash;
            w.word_length = acc_len;
            words_due.push_back(w);
        end
        acc_open = 1'b0;
        acc_hash = FNV_BASIS;
        acc_len  = '0;
    endfunction

    // Fold one accepted byte into the predicted word state.
    function automatic void fold_byte(input logic [7:0] raw, input logic last);
        logic [7:0] c;
        bit         letter;
        bit         joins;
        c = raw;
        if (raw >= CHAR_UPPER_A && raw <= CHAR_UPPER_Z)
        begin
            c = raw + CASE_OFFSET;
        end
        letter = (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
        joins  = acc_open ? (letter || c == CHAR_APOS) : letter;
        if (joins)
        begin
            acc_open = 1'b1;
            acc_hash = (acc_hash ^ {56'd0, c}) * FNV_PRIME;
            if (acc_len != LEN_MAX)
            begin
                acc_len = acc_len + 1'b1;
            end
            if (last)
            begin
                close_word(1'b1);
            end
        end
        else if (acc_open)
        begin
            close_word(1'b1);
        end
        else if (last)
        begin
            close_word(1'b0);
        end
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Offer one byte and hold it until the block takes it. Valid stays high
    // afterwards so back-to-back bytes go in without a bubble.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        wth_text_t   t;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap != 0)
        begin
            text_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        t.text_byte   = b;
        t.end_of_text = last;
        text_ch.data  = t;
        text_ch.valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!text_ch.ready);
        fold_byte(b, last);
        @(negedge clk);
    endtask

    // Stop offering bytes and wait until every predicted word has come out.
    task automatic drain_words();
        text_ch.valid = 1'b0;
        while (words_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Boundary characters, apostrophe rules and every way a word can end.
    task automatic test_directed_words();
        send_byte(CHAR_UPPER_A, 1'b0);
        send_byte(CHAR_LOWER_Z, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(CHAR_UPPER_Z, 1'b0);
        send_byte(8'h5b, 1'b0);
        // Word that ends in an apostrophe, closed by a backtick.
        send_byte(CHAR_LOWER_A, 1'b0);
        send_byte(CHAR_APOS, 1'b0);
        send_byte(8'h60, 1'b0);
        // A leading apostrophe is skipped.
        send_byte(CHAR_APOS, 1'b0);
        send_byte(8'h51, 1'b0);
        send_byte(8'h7b, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h6d, 1'b0);
        send_byte(8'hff, 1'b0);
        // Last byte inside a word is folded in before the word is given.
        send_byte(8'h80, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h63, 1'b1);
        // Last byte is a lone letter: a one-byte word.
        send_byte(8'h20, 1'b0);
        send_byte(8'h51, 1'b1);
        // Last byte with no word anywhere: nothing comes out.
        send_byte(8'h20, 1'b1);
        // Apostrophe as the last byte of an open word belongs to the word.
        send_byte(8'h69, 1'b0);
        send_byte(8'h74, 1'b0);
        send_byte(CHAR_APOS, 1'b1);
        // Apostrophe as the last byte with no word open.
        send_byte(CHAR_APOS, 1'b1);
        // Delimiter flagged last closes the open word.
        send_byte(8'h78, 1'b0);
        send_byte(8'h2e, 1'b1);
        drain_words();
    endtask

    // The receiver holds off for a long stretch while short words keep coming,
    // so the block has to stall its input.
    task automatic test_backpressure();
        rx_hold_cycles = 300;
        for (int i = 0; i < 40; i++)
        begin
            send_byte(rand_letter(), 1'b0);
            send_byte(rand_delim(), 1'b0);
        end
        drain_words();
    endtask

    // Mostly well-formed words with random content, plus raw noise bytes.
    task automatic test_random_text();
        int unsigned sent;
        int unsigned wlen;
        bit          ends_last;
        logic [7:0]  b;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                tx_gaps_on = ($urandom_range(0, 2) != 0);
                rx_gaps_on = ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                wlen      = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60)
                                                         : $urandom_range(1, 12);
                ends_last = ($urandom_range(0, 9) == 0);
                for (int unsigned i = 0; i < wlen; i++)
                begin
                    b = (i > 0 && $urandom_range(0, 5) == 0) ? CHAR_APOS : rand_letter();
                    send_byte(b, ends_last && (i == wlen - 1));
                    sent++;
                end
                if (!ends_last)
                begin
                    send_byte(rand_delim(), $urandom_range(0, 7) == 0);
                    sent++;
                end
            end
            else
            begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
                sent++;
            end
            if ($urandom_range(0, 99) == 0)
            begin
                drain_words();
            end
        end
        drain_words();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // Receiver: long hold-offs first, then random stalls when enabled.
    initial
    begin
        words_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
            begin
                words_ch.ready = 1'b0;
            end
            else if (rx_hold_cycles != 0)
            begin
                words_ch.ready = 1'b0;
                rx_hold_cycles--;
            end
            else if (rx_stall_left != 0)
            begin
                words_ch.ready = 1'b0;
                rx_stall_left--;
            end
            else if (rx_gaps_on && $urandom_range(0, 2) == 0)
            begin
                rx_stall_left  = pick_gap();
                words_ch.ready = (rx_stall_left == 0);
                if (rx_stall_left != 0)
                begin
                    rx_stall_left--;
                end
            end
            else
            begin
                words_ch.ready = 1'b1;
            end
        end
    end

    // Compare each result transaction with the oldest predicted word.
    initial
    begin
        wth_word_t got;
        wth_word_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && words_ch.valid && words_ch.ready)
            begin
                got = words_ch.data;
                if (words_due.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected word hash=%h length=%0d",
                                            got.word_hash, got.word_length));
                end
                else
                begin
                    want = words_due.pop_front();
                    if (got.word_hash !== want.word_hash)
                    begin
                        flag_mismatch($sformatf("word_hash got %h want %h",
                                                got.word_hash, want.word_hash));
                    end
                    if (got.word_length !== want.word_length)
                    begin
                        flag_mismatch($sformatf("word_length got %0d want %0d",
                                                got.word_length, want.word_length));
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either channel.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((text_ch.valid && text_ch.ready) || (words_ch.valid && words_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] timeout: no transaction for %0d cycles, %0d words pending",
                         $realtime, idle_cycles, words_due.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        rst_n          = 1'b0;
        text_ch.valid  = 1'b0;
        text_ch.data   = '0;
        mismatch_count = 0;
        tx_gaps_on     = 1'b1;
        rx_gaps_on     = 1'b1;
        rx_hold_cycles = 0;
        rx_stall_left  = 0;
        close_word(1'b0);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_words();
        test_backpressure();
        test_random_text();

        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: word_tokenizer_fnv1a_hash.f
src/wth_pkg.sv
src/wth_stream_if.sv
src/wth_tokenizer.sv
src/word_tokenizer_fnv1a_hash.sv
bench/word_tokenizer_fnv1a_hash_test.sv
